/* hdl/fixed_block_pool_allocator_top_defines.svh */
// assertion macros for the block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FBPA_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("fbpa: invariant violated");
`define FBPA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbpa: implication violated");
`else
`define FBPA_ASSERT(label, expr)
`define FBPA_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

/* hdl/fbpa_pkg.sv */
// types, codes and sizes shared by the block pool allocator
package fbpa_pkg;

  localparam int MAX_BLOCKS      = 256;
  localparam int ALIGN_BYTES     = 8;
  localparam int MAX_BLOCK_BYTES = 65536;

  localparam int IDX_W        = 8;
  localparam int CNT_W        = 9;
  localparam int SIZE_W       = 17;
  localparam int OFFSET_W     = 24;
  localparam int FREE_BYTES_W = 25;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;

  localparam logic [1:0] MODE_ALLOC       = 2'd0;
  localparam logic [1:0] MODE_ALLOC_CLEAR = 2'd1;
  localparam logic [1:0] MODE_FREE        = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LINK
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [IDX_W-1:0]        granted_index;
    logic [OFFSET_W-1:0]     block_offset;
    logic                    clear_needed;
    logic [CNT_W-1:0]        free_blocks;
    logic [FREE_BYTES_W-1:0] free_bytes;
  } rsp_t;

  // result before the size multiplications
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
    logic             clear_needed;
    logic [CNT_W-1:0] free_blocks;
  } res_t;

  // pool reinitialization on a register write
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
  } pool_load_t;

endpackage

/* hdl/fbpa_ram.sv */
// single port write, single port read ram with registered read data
module fbpa_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/fbpa_ctrl.sv */
// free list control: stack head, fresh index, free count and link memory
module fbpa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  fbpa_pkg::req_t             req,
  input  logic [fbpa_pkg::CNT_W-1:0] cnt,
  input  fbpa_pkg::pool_load_t       pool_load,
  output logic                       res_valid,
  output fbpa_pkg::res_t             res,
  input  logic                       res_taken,
  output logic                       link_wait
);
  import fbpa_pkg::*;

  ctrl_state_t      state, state_next;
  logic [CNT_W-1:0] freed_head;
  logic [CNT_W-1:0] fresh_next;
  logic [CNT_W-1:0] free_count;

  logic [CNT_W-1:0] stack_len;
  logic             accept;
  logic             pop_hit, pop_last, fresh_hit, free_ok;
  res_t             res_next;
  logic [CNT_W-1:0] link_rdata;
  logic             ram_we, ram_re;

  assign accept = req_valid && !req_stall;

  // entries counted on the freed stack
  assign stack_len = free_count - (cnt - fresh_next);

  always_comb begin
    pop_hit   = 1'b0;
    fresh_hit = 1'b0;
    free_ok   = 1'b0;
    pop_last  = (stack_len == CNT_W'(1));
    res_next.status        = STATUS_OK;
    res_next.granted_index = '0;
    res_next.clear_needed  = 1'b0;
    res_next.free_blocks   = free_count;
    case (req.mode)
      MODE_ALLOC, MODE_ALLOC_CLEAR: begin
        if (stack_len != '0 && freed_head < CNT_W'(MAX_BLOCKS)) begin
          pop_hit = 1'b1;
          res_next.granted_index = freed_head[IDX_W-1:0];
          res_next.clear_needed  = (req.mode == MODE_ALLOC_CLEAR);
          res_next.free_blocks   = free_count - CNT_W'(1);
        end else if (fresh_next < cnt) begin
          fresh_hit = 1'b1;
          res_next.granted_index = fresh_next[IDX_W-1:0];
          res_next.clear_needed  = (req.mode == MODE_ALLOC_CLEAR);
          res_next.free_blocks   = free_count - CNT_W'(1);
        end else begin
          res_next.status = STATUS_EMPTY;
        end
      end
      MODE_FREE: begin
        if ({1'b0, req.block_index} < cnt) begin
          free_ok = 1'b1;
          if (free_count < cnt) begin
            res_next.free_blocks = free_count + CNT_W'(1);
          end
        end else begin
          res_next.status = STATUS_BAD_INDEX;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && pop_hit && !pop_last) begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_stall = 1'b1;
    link_wait = 1'b0;
    case (state)
      ST_IDLE: req_stall = res_valid && !res_taken;
      ST_LINK: link_wait = 1'b1;
      default: ;
    endcase
    ram_we = accept && free_ok;
    ram_re = accept && pop_hit && !pop_last;
  end

  fbpa_ram #(
    .DEPTH(MAX_BLOCKS),
    .WIDTH(CNT_W)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(req.block_index),
    .wdata(freed_head),
    .re   (ram_re),
    .raddr(freed_head[IDX_W-1:0]),
    .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      freed_head <= CNT_W'(MAX_BLOCKS);
      fresh_next <= '0;
      free_count <= CNT_W'(MAX_BLOCKS);
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (pool_load.load) begin
        freed_head <= CNT_W'(MAX_BLOCKS);
        fresh_next <= '0;
        free_count <= pool_load.count;
      end else if (state == ST_LINK) begin
        freed_head <= link_rdata;
      end else if (accept) begin
        free_count <= res_next.free_blocks;
        if (pop_hit && pop_last) begin
          freed_head <= CNT_W'(MAX_BLOCKS);
        end
        if (fresh_hit) begin
          fresh_next <= fresh_next + CNT_W'(1);
        end
        if (free_ok) begin
          freed_head <= {1'b0, req.block_index};
        end
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_taken) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

/* hdl/fbpa_resp.sv */
// response register: offset and free byte products
module fbpa_resp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_valid,
  input  fbpa_pkg::res_t              res,
  output logic                        res_taken,
  input  logic [fbpa_pkg::SIZE_W-1:0] slot_bytes,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output fbpa_pkg::rsp_t              rsp
);
  import fbpa_pkg::*;

  logic [IDX_W+SIZE_W-1:0] offset_prod;
  logic [CNT_W+SIZE_W-1:0] bytes_prod;

  assign res_taken   = res_valid && (!rsp_valid || !rsp_stall);
  assign offset_prod = (IDX_W+SIZE_W)'(res.granted_index) * (IDX_W+SIZE_W)'(slot_bytes);
  assign bytes_prod  = (CNT_W+SIZE_W)'(res.free_blocks) * (CNT_W+SIZE_W)'(slot_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_taken) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      rsp.status        <= res.status;
      rsp.granted_index <= res.granted_index;
      rsp.block_offset  <= offset_prod[OFFSET_W-1:0];
      rsp.clear_needed  <= res.clear_needed;
      rsp.free_blocks   <= res.free_blocks;
      rsp.free_bytes    <= bytes_prod[FREE_BYTES_W-1:0];
    end
  end

endmodule

/* hdl/fixed_block_pool_allocator_top.sv */
// block pool allocator top level: registers, free list control, response stage
//
//   channel  signals                              direction  transfer when
//   req      req_valid, req_stall, req            in         valid & !stall
//   rsp      rsp_valid, rsp_stall, rsp            out        valid & !stall
//   cfg      cfg_valid, cfg_ready, cfg_index/data in         valid & ready
//
// a free, a fresh allocate, an empty allocate, an unused mode and a pop of the last
// stacked entry leave the control idle; an allocate that pops the freed stack with more
// entries below holds req_stall high in the link state while the next head is read
// from the link memory. a result is registered in the control, then in the response
// stage; one result can wait in the response stage while the next one is computed. reset
// gives 256 blocks of 64 bytes, an empty freed stack; the link memory needs no clearing.
`include "fixed_block_pool_allocator_top_defines.svh"

module fixed_block_pool_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  fbpa_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output fbpa_pkg::rsp_t                  rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbpa_pkg::*;

  logic [CNT_W-1:0]  block_cnt;
  logic [SIZE_W-1:0] slot_bytes;

  logic              cfg_write;
  logic [CNT_W-1:0]  cnt_clamp;
  logic [SIZE_W-1:0] bytes_clamp;
  logic [SIZE_W:0]   bytes_sum;
  logic [SIZE_W-1:0] bytes_aligned;
  pool_load_t        pool_load;

  logic              res_valid;
  res_t              res;
  logic              res_taken;
  logic              link_wait;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    cnt_clamp = cfg_data[CNT_W-1:0];
    if (cnt_clamp == '0) begin
      cnt_clamp = CNT_W'(1);
    end else if (cnt_clamp > CNT_W'(MAX_BLOCKS)) begin
      cnt_clamp = CNT_W'(MAX_BLOCKS);
    end
    bytes_clamp = cfg_data[SIZE_W-1:0];
    if (bytes_clamp == '0) begin
      bytes_clamp = SIZE_W'(1);
    end else if (bytes_clamp > SIZE_W'(MAX_BLOCK_BYTES)) begin
      bytes_clamp = SIZE_W'(MAX_BLOCK_BYTES);
    end
    // round up to the alignment
    bytes_sum     = {1'b0, bytes_clamp} + (SIZE_W+1)'(ALIGN_BYTES - 1);
    bytes_aligned = SIZE_W'((bytes_sum / (SIZE_W+1)'(ALIGN_BYTES))
                            * (SIZE_W+1)'(ALIGN_BYTES));
  end

  always_comb begin
    pool_load.load  = 1'b0;
    pool_load.count = block_cnt;
    if (cfg_write) begin
      case (cfg_index)
        CFG_BLOCK_COUNT: begin
          pool_load.load  = 1'b1;
          pool_load.count = cnt_clamp;
        end
        CFG_BLOCK_BYTES: pool_load.load = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_cnt  <= CNT_W'(MAX_BLOCKS);
      slot_bytes <= SIZE_W'(64);
    end else if (cfg_write) begin
      if (cfg_index == CFG_BLOCK_COUNT) begin
        block_cnt <= cnt_clamp;
      end
      if (cfg_index == CFG_BLOCK_BYTES) begin
        slot_bytes <= bytes_aligned;
      end
    end
  end

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .cnt      (block_cnt),
    .pool_load(pool_load),
    .res_valid(res_valid),
    .res      (res),
    .res_taken(res_taken),
    .link_wait(link_wait)
  );

  fbpa_resp u_resp (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken),
    .slot_bytes(slot_bytes),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // no request transfer while the next head is read from the link memory
  `FBPA_ASSERT_IMPLY(a_link_wait_stalls, link_wait, req_stall)
  // a failed request grants nothing
  `FBPA_ASSERT_IMPLY(a_fail_no_grant, rsp_valid && rsp.status != STATUS_OK,
                     rsp.granted_index == '0 && !rsp.clear_needed && rsp.block_offset == '0)
  // an empty pool leaves no free block
  `FBPA_ASSERT_IMPLY(a_empty_zero_free, rsp_valid && rsp.status == STATUS_EMPTY,
                     rsp.free_blocks == '0)

endmodule

/* verif/fixed_block_pool_allocator_top_tb.sv */
// self-checking testbench for the block pool allocator: free list prediction and response checks
module fixed_block_pool_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam logic [1:0]           MODE_UNUSED       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3       = 2'd3;
  localparam int                   RESET_BLOCK_BYTES = 64;
  localparam int                   PHASES            = 10;
  localparam int                   PHASE_ITEMS       = 186;
  localparam int                   FREE_SHARE        = 35;
  localparam int                   LONG_HOLD         = 80;
  localparam int                   DRAIN_CYCLES      = 4;
  localparam int                   CYCLE_LIMIT       = 400000;

  // -1 picks a small random count, -2 any 9-bit value; -1 for bytes is any 17-bit value
  localparam int PHASE_COUNT [PHASES] = '{0, 1, 511, 2, 3, 8, -1, -2, 256, -1};
  localparam int PHASE_BYTES [PHASES] = '{0, 1, 131071, 65536, 7, 9, -1, -1, 8, -1};
  localparam int PHASE_ALLOC [PHASES] = '{45, 45, 58, 50, 50, 45, 50, 45, 58, 45};

  class pool_scoreboard;
    logic [CNT_W-1:0]  block_count;
    logic [SIZE_W-1:0] block_bytes;
    logic [CNT_W-1:0]  next_link [MAX_BLOCKS];
    logic [CNT_W-1:0]  freed_head;
    logic [CNT_W-1:0]  fresh_next;
    logic [CNT_W-1:0]  free_count;
    rsp_t              predicted_rsp [$];
    logic [IDX_W-1:0]  held [$];
    int errors, accepted, checked, grants, empties, bad_frees, reg_writes;

    function new();
      block_count = CNT_W'(MAX_BLOCKS);
      block_bytes = SIZE_W'(RESET_BLOCK_BYTES);
      foreach (next_link[i]) next_link[i] = '0;
      reinit();
    endfunction

    function int eff_count();
      int c;
      c = block_count;
      if (c == 0) c = 1;
      if (c > MAX_BLOCKS) c = MAX_BLOCKS;
      return c;
    endfunction

    function int aligned_size();
      int b;
      b = block_bytes;
      if (b == 0) b = 1;
      if (b > MAX_BLOCK_BYTES) b = MAX_BLOCK_BYTES;
      return ((b + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function void reinit();
      freed_head = CNT_W'(MAX_BLOCKS);
      fresh_next = '0;
      free_count = CNT_W'(eff_count());
      held.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_BLOCK_COUNT: begin
          block_count = data[CNT_W-1:0];
          reinit();
        end
        CFG_BLOCK_BYTES: begin
          block_bytes = data;
          reinit();
        end
        default: ;
      endcase
    endfunction

    function void take_request(req_t r);
      rsp_t             want;
      int               cnt;
      int               size;
      int               stack_len;
      logic [IDX_W-1:0] grant;
      bit               ok;
      int               k;
      cnt = eff_count();
      size = aligned_size();
      want = '0;
      ok = 1'b0;
      grant = '0;
      accepted++;
      case (r.mode)
        MODE_ALLOC, MODE_ALLOC_CLEAR: begin
          // freed stack entries still counted; extra links from double frees never count
          stack_len = int'(free_count) - (cnt - int'(fresh_next));
          if (stack_len > 0 && freed_head < MAX_BLOCKS) begin
            grant = freed_head[IDX_W-1:0];
            freed_head = (stack_len == 1) ? CNT_W'(MAX_BLOCKS) : next_link[grant];
            free_count--;
            ok = 1'b1;
          end else if (fresh_next < cnt) begin
            grant = fresh_next[IDX_W-1:0];
            fresh_next++;
            free_count--;
            ok = 1'b1;
          end else begin
            want.status = STATUS_EMPTY;
            empties++;
          end
          if (ok) begin
            want.granted_index = grant;
            want.block_offset = OFFSET_W'(longint'(grant) * size);
            want.clear_needed = (r.mode == MODE_ALLOC_CLEAR);
            held.push_back(grant);
            grants++;
          end
        end
        MODE_FREE: begin
          if (r.block_index >= cnt) begin
            want.status = STATUS_BAD_INDEX;
            bad_frees++;
          end else begin
            next_link[r.block_index] = freed_head;
            freed_head = {1'b0, r.block_index};
            if (free_count < cnt) free_count++;
            for (k = 0; k < held.size(); k++) begin
              if (held[k] == r.block_index) begin
                held.delete(k);
                break;
              end
            end
          end
        end
        default: ;
      endcase
      want.free_blocks = free_count;
      want.free_bytes = FREE_BYTES_W'(longint'(free_count) * size);
      predicted_rsp.push_back(want);
    endfunction

    function void cmp_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      if (predicted_rsp.size() == 0) begin
        $error("response transfer with no request outstanding: %p", got);
        errors++;
        return;
      end
      want = predicted_rsp.pop_front();
      checked++;
      cmp_field("status", want.status, got.status);
      cmp_field("granted_index", want.granted_index, got.granted_index);
      cmp_field("block_offset", want.block_offset, got.block_offset);
      cmp_field("clear_needed", want.clear_needed, got.clear_needed);
      cmp_field("free_blocks", want.free_blocks, got.free_blocks);
      cmp_field("free_bytes", want.free_bytes, got.free_bytes);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pool_scoreboard sb;
  bit             quiet = 1'b0;
  int             hold_asked = 0;
  int             hold_seen = 0;
  int             hold_left = 0;
  int             cycles = 0;

  fixed_block_pool_allocator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               sb.predicted_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off counted here when asked for
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(99) < 6);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_rsp(rsp);
  end

  task automatic send_request(req_t r);
    int gap;
    if (!quiet && $urandom_range(99) < 6) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        req_valid <= 1'b0;
      end
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    sb.take_request(r);
  endtask

  task automatic send_mode(logic [1:0] mode, int idx);
    req_t r;
    r.mode = mode;
    r.block_index = IDX_W'(idx);
    send_request(r);
  endtask

  // lower valid and let every predicted response come back
  task automatic drain_pipeline();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.predicted_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, CFG_DATA_W'(data));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t next_request(int alloc_pct);
    req_t r;
    int   roll;
    r.block_index = IDX_W'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < alloc_pct || (roll < alloc_pct + FREE_SHARE && sb.held.size() == 0)) begin
      r.mode = $urandom_range(1) ? MODE_ALLOC_CLEAR : MODE_ALLOC;
    end else if (roll < alloc_pct + FREE_SHARE) begin
      r.mode = MODE_FREE;
      r.block_index = sb.held[$urandom_range(sb.held.size() - 1)];
    end else if (roll < 96) begin
      // stray frees: double frees, never-used blocks and indices around the pool edge
      r.mode = MODE_FREE;
      if ($urandom_range(1)) r.block_index = IDX_W'(sb.eff_count() - $urandom_range(1));
    end else begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  task automatic run_directed();
    // reset pool: fresh grants, frees onto the stack, then pops in lifo order
    send_mode(MODE_ALLOC, 0);
    send_mode(MODE_ALLOC_CLEAR, 0);
    send_mode(MODE_FREE, 255);
    send_mode(MODE_FREE, 0);
    send_mode(MODE_UNUSED, 170);
    send_mode(MODE_ALLOC, 85);
    send_mode(MODE_ALLOC, 0);
    send_mode(MODE_ALLOC, 0);
    drain_pipeline();
    write_reg(CFG_BLOCK_COUNT, 2);
    write_reg(CFG_BLOCK_BYTES, MAX_BLOCK_BYTES);
    // two largest blocks: empty pool, bad frees, double free handing a block out twice
    send_mode(MODE_ALLOC_CLEAR, 0);
    send_mode(MODE_ALLOC, 0);
    send_mode(MODE_ALLOC, 0);
    send_mode(MODE_FREE, 2);
    send_mode(MODE_FREE, 255);
    send_mode(MODE_FREE, 1);
    send_mode(MODE_ALLOC_CLEAR, 0);
    send_mode(MODE_FREE, 0);
    send_mode(MODE_FREE, 0);
    send_mode(MODE_ALLOC, 0);
    send_mode(MODE_ALLOC, 0);
    send_mode(MODE_ALLOC, 0);
    send_mode(MODE_UNUSED, 0);
    drain_pipeline();
  endtask

  initial begin
    int count_val;
    int bytes_val;
    sb = new();
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      count_val = PHASE_COUNT[p];
      if (count_val == -1) count_val = $urandom_range(1, 16);
      else if (count_val == -2) count_val = $urandom_range(511);
      bytes_val = PHASE_BYTES[p];
      if (bytes_val == -1) bytes_val = $urandom_range(131071);
      write_reg(CFG_BLOCK_COUNT, count_val);
      write_reg(CFG_BLOCK_BYTES, bytes_val);
      if (p == 5) begin
        write_reg(CFG_SPARE_2, $urandom_range(131071));
        write_reg(CFG_SPARE_3, $urandom_range(131071));
      end
      quiet = (p == 3);
      // long receiver hold-off while requests keep coming, so the input backs up
      if (p == 4) hold_asked++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_request(next_request(PHASE_ALLOC[p]));
        if (p == 6 && i == PHASE_ITEMS / 2) drain_pipeline();
      end
      drain_pipeline();
      quiet = 1'b0;
    end

    repeat (10) @(posedge clk);
    $display("%0d requests: %0d grants, %0d empty-pool allocates, %0d out-of-range frees",
             sb.accepted, sb.grants, sb.empties, sb.bad_frees);
    $display("%0d responses checked over %0d register writes, incl. extreme sizes",
             sb.checked, sb.reg_writes);
    if (sb.errors == 0 && sb.predicted_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
